// ===== sv/fir4_decimate_by_two_defines.svh =====
// assertion macros for the fir4 decimator
`ifndef FIR4_DECIMATE_BY_TWO_DEFINES_SVH
`define FIR4_DECIMATE_BY_TWO_DEFINES_SVH

`ifndef SYNTHESIS
`define FIR4D_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fir4d property violated");
`define FIR4D_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("fir4d forbidden condition seen");
`else
`define FIR4D_ASSERT(label, prop)
`define FIR4D_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== sv/fir4d_pkg.sv =====
package fir4d_pkg;

  localparam int unsigned NumTaps  = 4;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ProdW    = 2 * SampleW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned FracBits = 15;
  localparam int unsigned CfgIdxW  = 2;

  typedef logic signed [SampleW-1:0] samp_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [SumW-1:0]    sum_t;

  typedef logic [NumTaps-1:0][SampleW-1:0] tap_vec_t;

  // taps[0] is the newest sample
  typedef struct packed {
    tap_vec_t taps;
    logic     last;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  localparam sum_t  RoundAdd = SumW'(16384);
  localparam samp_t SatMax   = 16'sh7fff;
  localparam samp_t SatMin   = 16'sh8000;

  localparam tap_vec_t CoefReset = {16'sd3277, 16'sd13107, 16'sd13107, 16'sd3277};

endpackage

// ===== sv/fir4d_front.sv =====
module fir4d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fir4d_pkg::samp_t in_sample_i,
  input  logic             in_last_i,
  input  logic             q_full_i,
  output fir4d_pkg::push_t q_push_o,
  output logic             keep_phase_o
);
  import fir4d_pkg::*;

  samp_t delay_q [NumTaps-1];
  logic  keep_phase_q;
  logic  in_xfer;

  always_comb begin
    in_ready_o = !q_full_i;
    in_xfer    = in_valid_i && in_ready_o;
    q_push_o.valid = in_xfer && (keep_phase_q || in_last_i);
    q_push_o.entry.taps[0] = in_sample_i;
    for (int k = 1; k < NumTaps; k++) begin
      q_push_o.entry.taps[k] = delay_q[k-1];
    end
    q_push_o.entry.last = in_last_i;
    keep_phase_o = keep_phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_phase_q <= 1'b0;
      for (int k = 0; k < NumTaps - 1; k++) begin
        delay_q[k] <= '0;
      end
    end else if (in_xfer) begin
      keep_phase_q <= in_last_i ? 1'b0 : !keep_phase_q;
      delay_q[0]   <= in_sample_i;
      for (int k = 1; k < NumTaps - 1; k++) begin
        delay_q[k] <= delay_q[k-1];
      end
    end
  end

endmodule

// ===== sv/fir4d_queue.sv =====
module fir4d_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fir4d_pkg::push_t  push_i,
  output logic              full_o,
  output logic              valid_o,
  output fir4d_pkg::entry_t entry_o,
  input  logic              pop_i
);
  import fir4d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  always_comb begin
    full_o  = (count_q == CntW'(Depth));
    valid_o = (count_q != '0);
    entry_o = mem_q[rd_ptr_q];
    do_push = push_i.valid && !full_o;
    do_pop  = pop_i && valid_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ===== sv/fir4d_back.sv =====
module fir4d_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fir4d_pkg::tap_vec_t coef_i,
  input  logic                q_valid_i,
  input  fir4d_pkg::entry_t   q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fir4d_pkg::samp_t    out_sample_o,
  output logic                out_last_o
);
  import fir4d_pkg::*;

  // multiply stage
  logic    s1_valid_q, s1_last_q;
  prod_t   s1_prod_q [NumTaps];
  // sum stage
  logic    s2_valid_q, s2_last_q;
  sum_t    s2_sum_q;
  // output register
  logic    out_valid_q, out_last_q;
  samp_t   out_sample_q;

  logic    adv1, adv2, adv3;
  sum_t    sum_d;
  logic signed [SumW-FracBits-1:0] shifted;
  samp_t   sat_d;

  always_comb begin
    adv3    = !out_valid_q || out_ready_i;
    adv2    = !s2_valid_q || adv3;
    adv1    = !s1_valid_q || adv2;
    q_pop_o = q_valid_i && adv1;

    sum_d = RoundAdd;
    for (int k = 0; k < NumTaps; k++) begin
      sum_d = sum_d + SumW'(s1_prod_q[k]);
    end

    // floor shift, then clamp to the sample range
    shifted = s2_sum_q[SumW-1:FracBits];
    if (shifted > $signed((SumW-FracBits)'(SatMax))) begin
      sat_d = SatMax;
    end else if (shifted < $signed((SumW-FracBits)'(SatMin))) begin
      sat_d = SatMin;
    end else begin
      sat_d = shifted[SampleW-1:0];
    end

    out_valid_o  = out_valid_q;
    out_sample_o = out_sample_q;
    out_last_o   = out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= q_valid_i;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (adv3) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_last_q <= q_entry_i.last;
      for (int k = 0; k < NumTaps; k++) begin
        s1_prod_q[k] <= $signed(q_entry_i.taps[k]) * $signed(coef_i[k]);
      end
    end
    if (adv2 && s1_valid_q) begin
      s2_sum_q  <= sum_d;
      s2_last_q <= s1_last_q;
    end
    if (adv3 && s2_valid_q) begin
      out_sample_q <= sat_d;
      out_last_q   <= s2_last_q;
    end
  end

endmodule

// ===== sv/fir4_decimate_by_two.sv =====
// Four-tap FIR with decimation by two. One sample is accepted per clock while the queue
// is not full; odd-position samples and every sample flagged last produce a result, which
// goes through the queue, multiply stage, sum stage and output register. A stalled output
// backs up the pipeline and then the queue of QueueDepth entries; input ready drops only
// when that queue is full. The phase restarts at "drop" after each last sample, while the
// delay line runs across packet boundaries. Coefficients are Q15 and should be written
// only while the block is idle.
`include "fir4_decimate_by_two_defines.svh"

module fir4_decimate_by_two #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fir4d_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  fir4d_pkg::samp_t                cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fir4d_pkg::samp_t                in_sample_i,
  input  logic                            in_last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fir4d_pkg::samp_t                out_sample_o,
  output logic                            out_last_o
);
  import fir4d_pkg::*;

  tap_vec_t coef_q;
  push_t    q_push;
  logic     q_full, q_valid, q_pop, keep_phase;
  entry_t   q_entry;
  logic     in_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefReset;
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  fir4d_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_sample_i,
    .in_last_i,
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .keep_phase_o (keep_phase)
  );

  fir4d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  fir4d_back u_back (
    .clk_i,
    .rst_ni,
    .coef_i    (coef_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_ready_i,
    .out_sample_o,
    .out_last_o
  );

  assign in_xfer = in_valid_i && in_ready_o;

  `FIR4D_ASSERT_NEVER(a_queue_overflow, q_push.valid && q_full)
  `FIR4D_ASSERT(a_last_always_kept, (in_xfer && in_last_i) |-> q_push.valid)
  `FIR4D_ASSERT(a_phase_toggles, (in_xfer && !in_last_i) |=> (keep_phase != $past(keep_phase)))
  `FIR4D_ASSERT(a_last_clears_phase, (in_xfer && in_last_i) |=> !keep_phase)

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fir4d_pkg::*;

  typedef enum logic [CfgIdxW-1:0] {
    IdxTap0,
    IdxTap1,
    IdxTap2,
    IdxTap3
  } coef_idx_e;

  typedef struct {
    samp_t sample;
    bit    last;
  } filter_out_t;

  localparam int CycleLimit = 300000;
  localparam int SettleCycles = 20;
  localparam int HoldCycles = 150;
  localparam int PhaseItems = 120;

  // expected filter outputs, predicted from accepted input samples
  class fir_scoreboard;
    samp_t       coef[NumTaps];
    samp_t       history[NumTaps-1];
    bit          keep_phase;
    filter_out_t expected[$];
    int          mismatches;
    int          checked;

    function new();
      for (int k = 0; k < NumTaps; k++) begin
        coef[k] = CoefReset[k];
      end
      for (int k = 0; k < NumTaps - 1; k++) begin
        history[k] = '0;
      end
      keep_phase = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void note_sample(samp_t s, bit last);
      longint      acc;
      longint      r;
      filter_out_t res;
      acc = longint'(s) * longint'(coef[0]);
      for (int k = 1; k < NumTaps; k++) begin
        acc += longint'(history[k-1]) * longint'(coef[k]);
      end
      r = (acc + longint'(RoundAdd)) >>> FracBits;
      if (r > longint'(SatMax)) r = longint'(SatMax);
      else if (r < longint'(SatMin)) r = longint'(SatMin);
      for (int k = NumTaps - 2; k > 0; k--) begin
        history[k] = history[k-1];
      end
      history[0] = s;
      if (keep_phase || last) begin
        res.sample = samp_t'(r);
        res.last = last;
        expected.push_back(res);
      end
      keep_phase = last ? 1'b0 : !keep_phase;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(samp_t s, bit last);
      filter_out_t e;
      if (expected.size() == 0) begin
        report($sformatf("output %0d (last %0b) with none expected", s, last));
        return;
      end
      e = expected.pop_front();
      checked++;
      if (s != e.sample) report($sformatf("sample %0d, expected %0d", s, e.sample));
      if (last != e.last) report($sformatf("last %0b, expected %0b", last, e.last));
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  coef_idx_e cfg_idx_i = IdxTap0;
  samp_t     cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  samp_t     in_sample_i = '0;
  logic      in_last_i = 1'b0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  samp_t     out_sample_o;
  logic      out_last_o;

  fir_scoreboard sb = new();

  int cycles = 0;
  int items_sent = 0;
  int settings = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  fir4_decimate_by_two dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_sample_i (in_sample_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_sample_o(out_sample_o),
    .out_last_o  (out_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_sample_o, out_last_o);
  end

  // output stalls: stretches of different ready patterns, plus one long hold-off
  initial begin
    int mode;
    int run_len;
    int period;
    int hold_left;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      run_len = $urandom_range(4, 60);
      period = $urandom_range(2, 5);
      for (int k = 0; k < run_len; k++) begin
        @(posedge clk_i);
        if (hold_req && !hold_done) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end
        if (hold_left > 0) begin
          out_ready_i <= 1'b0;
          hold_left--;
        end else begin
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= $urandom_range(0, 1);
            2: out_ready_i <= (k % period) == 0;
            default: out_ready_i <= $urandom_range(0, 7) != 0;
          endcase
        end
      end
    end
  end

  task write_coefs(samp_t c0, samp_t c1, samp_t c2, samp_t c3);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= IdxTap0;
    cfg_data_i <= c0;
    @(posedge clk_i);
    cfg_idx_i <= IdxTap1;
    cfg_data_i <= c1;
    @(posedge clk_i);
    cfg_idx_i <= IdxTap2;
    cfg_data_i <= c2;
    @(posedge clk_i);
    cfg_idx_i <= IdxTap3;
    cfg_data_i <= c3;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.coef[IdxTap0] = c0;
    sb.coef[IdxTap1] = c1;
    sb.coef[IdxTap2] = c2;
    sb.coef[IdxTap3] = c3;
    settings++;
  endtask

  // bursts of transfers separated by random gaps, or gap-free when steady
  task pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = steady ? 1000 : $urandom_range(1, 20);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task send_item(samp_t s, bit last);
    in_valid_i <= 1'b1;
    in_sample_i <= s;
    in_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s, last);
    items_sent++;
    pace();
  endtask

  task drain();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.expected.size() != 0) begin
      sb.report($sformatf("%0d filter outputs never arrived", sb.expected.size()));
      sb.expected.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic samp_t rand_sample();
    case ($urandom_range(0, 7))
      0: return SatMax;
      1: return SatMin;
      2, 3: return samp_t'($urandom_range(0, 512) - 256);
      default: return samp_t'($urandom);
    endcase
  endfunction

  task send_packet(int len, bit closed);
    for (int i = 0; i < len; i++) begin
      send_item(rand_sample(), closed && i == len - 1);
    end
  endtask

  initial begin
    int phase_items;
    int len;
    samp_t c[NumTaps];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients: phase handling around last flags
    for (int i = 0; i < 4; i++) send_item(SatMax, 1'b0);
    for (int i = 0; i < 4; i++) send_item(SatMin, 1'b0);
    send_item(16'sd0, 1'b1);
    send_item(16'sd100, 1'b1);
    send_item(16'sd5, 1'b0);
    send_item(16'sd7, 1'b1);
    drain();

    // saturation in both directions
    write_coefs(SatMax, SatMax, SatMax, SatMax);
    for (int i = 0; i < 3; i++) send_item(SatMax, 1'b0);
    send_item(SatMin, 1'b1);
    drain();
    write_coefs(SatMin, SatMin, SatMin, SatMin);
    send_item(SatMin, 1'b0);
    send_item(SatMin, 1'b0);
    send_item(SatMax, 1'b0);
    send_item(SatMax, 1'b1);
    drain();
    write_coefs(SatMax, SatMin, 16'sd0, 16'sd1);
    send_item(SatMax, 1'b0);
    send_item(SatMin, 1'b0);
    send_item(SatMax, 1'b0);
    send_item(SatMin, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      for (int k = 0; k < NumTaps; k++) begin
        case ($urandom_range(0, 4))
          0: c[k] = $urandom_range(0, 1) ? SatMax : SatMin;
          1: c[k] = samp_t'($urandom_range(0, 8192) - 4096);
          default: c[k] = samp_t'($urandom);
        endcase
        if (p == 3) c[k] = CoefReset[k];
      end
      write_coefs(c[0], c[1], c[2], c[3]);
      if (p == 2) begin
        steady = 1'b1;
        hold_req = 1'b1;
      end
      burst_left = 0;
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        send_packet(len, $urandom_range(0, 9) != 0);
        phase_items += len;
      end
      drain();
      steady = 1'b0;
      burst_left = 0;
    end

    $display("%0d samples sent under %0d coefficient settings, %0d filter outputs checked",
             items_sent, settings, sb.checked);
    $display("covered saturation, last flags on both phases and a long output stall");
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
